/* hdl/rc4_stream_cipher_assert.svh */
// Assertion macros shared by the RC4 cipher RTL.
`ifndef RC4_STREAM_CIPHER_ASSERT_SVH
`define RC4_STREAM_CIPHER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RC4_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rc4 same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RC4_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rc4 next-cycle check failed");

`endif

/* hdl/rc4_pkg.sv */
// Shared constants, datapath command and status types for the RC4 cipher.
package rc4_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned BOX_DEPTH     = 256;
  localparam int unsigned BOX_ADDR_W    = $clog2(BOX_DEPTH);
  localparam int unsigned KEY_BYTES     = 16;
  localparam int unsigned KEY_POS_W     = $clog2(KEY_BYTES);
  localparam int unsigned KEY_LEN_W     = 5;
  localparam int unsigned MAX_KEY_BYTES = 16;
  localparam int unsigned REG_W         = 64;
  localparam int unsigned APB_ADDR_W    = 5;
  localparam int unsigned REG_IDX_W     = 2;
  localparam int unsigned REG_IDX_LSB   = 3;

  localparam logic [REG_IDX_W-1:0] REG_KEY_LOW    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_KEY_HIGH   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_KEY_LENGTH = 2'd2;

  localparam logic [KEY_LEN_W-1:0] KEY_LENGTH_RESET = KEY_LEN_W'(16);

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLEAR,
    DP_FILL,
    DP_KS_RD_A,
    DP_KS_RD_B,
    DP_KS_WR_A,
    DP_KS_WR_B,
    DP_GEN_RD_I,
    DP_GEN_RD_J,
    DP_GEN_SWAP,
    DP_GEN_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   capture;
  } dp_cmd_t;

  typedef struct packed {
    logic i_last;
    logic out_free;
  } dp_status_t;

endpackage

/* hdl/rc4_stream_if.sv */
// Valid/ready stream interfaces for the cipher input and output bytes.
interface rc4_in_if;
  logic                       valid;
  logic                       ready;
  logic [rc4_pkg::BYTE_W-1:0] data_byte;
  logic                       first_of_message;

  modport source (output valid, output data_byte, output first_of_message, input ready);
  modport sink (input valid, input data_byte, input first_of_message, output ready);
endinterface

interface rc4_out_if;
  logic                       valid;
  logic                       ready;
  logic [rc4_pkg::BYTE_W-1:0] out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink (input valid, input out_byte, output ready);
endinterface

/* hdl/rc4_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rc4_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/rc4_ctrl.sv */
// Sequencer for key schedule and keystream generation.
module rc4_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                first_i,
  output logic                in_ready_o,
  input  rc4_pkg::dp_status_t status_i,
  output rc4_pkg::dp_cmd_t    cmd_o
);
  import rc4_pkg::*;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_CLEAR    = 4'd1;
  localparam logic [3:0] ST_FILL     = 4'd2;
  localparam logic [3:0] ST_KS_RD_A  = 4'd3;
  localparam logic [3:0] ST_KS_RD_B  = 4'd4;
  localparam logic [3:0] ST_KS_WR_A  = 4'd5;
  localparam logic [3:0] ST_KS_WR_B  = 4'd6;
  localparam logic [3:0] ST_POST     = 4'd7;
  localparam logic [3:0] ST_GEN_RD_I = 4'd8;
  localparam logic [3:0] ST_GEN_RD_J = 4'd9;
  localparam logic [3:0] ST_GEN_SWAP = 4'd10;
  localparam logic [3:0] ST_GEN_OUT  = 4'd11;

  logic [3:0] state_q, state_d;
  logic       keyed_q, keyed_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d       = state_q;
    keyed_d       = keyed_q;
    cmd_o.op      = DP_NOP;
    cmd_o.capture = accept;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (first_i || !keyed_q) ? ST_CLEAR : ST_GEN_RD_I;
        end
      end
      ST_CLEAR: begin
        cmd_o.op = DP_CLEAR;
        state_d  = ST_FILL;
      end
      ST_FILL: begin
        cmd_o.op = DP_FILL;
        if (status_i.i_last) begin
          state_d = ST_KS_RD_A;
        end
      end
      ST_KS_RD_A: begin
        cmd_o.op = DP_KS_RD_A;
        state_d  = ST_KS_RD_B;
      end
      ST_KS_RD_B: begin
        cmd_o.op = DP_KS_RD_B;
        state_d  = ST_KS_WR_A;
      end
      ST_KS_WR_A: begin
        cmd_o.op = DP_KS_WR_A;
        state_d  = ST_KS_WR_B;
      end
      ST_KS_WR_B: begin
        cmd_o.op = DP_KS_WR_B;
        state_d  = status_i.i_last ? ST_POST : ST_KS_RD_A;
      end
      ST_POST: begin
        // indices restart from zero once the box is keyed
        cmd_o.op = DP_CLEAR;
        keyed_d  = 1'b1;
        state_d  = ST_GEN_RD_I;
      end
      ST_GEN_RD_I: begin
        cmd_o.op = DP_GEN_RD_I;
        state_d  = ST_GEN_RD_J;
      end
      ST_GEN_RD_J: begin
        cmd_o.op = DP_GEN_RD_J;
        state_d  = ST_GEN_SWAP;
      end
      ST_GEN_SWAP: begin
        cmd_o.op = DP_GEN_SWAP;
        state_d  = ST_GEN_OUT;
      end
      ST_GEN_OUT: begin
        // hold until the output register can take the result
        if (status_i.out_free) begin
          cmd_o.op = DP_GEN_OUT;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      keyed_q <= 1'b0;
    end else begin
      state_q <= state_d;
      keyed_q <= keyed_d;
    end
  end

endmodule

/* hdl/rc4_datapath.sv */
// Box memory, indices, key selection and output register of the RC4 cipher.
module rc4_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  rc4_pkg::dp_cmd_t                     cmd_i,
  output rc4_pkg::dp_status_t                  status_o,
  input  logic [rc4_pkg::BYTE_W-1:0]           data_byte_i,
  input  logic [rc4_pkg::REG_W-1:0]            key_low_i,
  input  logic [rc4_pkg::REG_W-1:0]            key_high_i,
  input  logic [rc4_pkg::KEY_LEN_W-1:0]        key_length_i,
  output logic [rc4_pkg::BYTE_W-1:0]           out_byte_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i
);
  import rc4_pkg::*;

  localparam logic [KEY_LEN_W-1:0] LEN_MAX = KEY_LEN_W'(MAX_KEY_BYTES);
  localparam logic [KEY_LEN_W-1:0] LEN_ONE = KEY_LEN_W'(1);

  logic [BOX_ADDR_W-1:0] i_q, i_d, j_q, j_d, t_q, t_d;
  logic [KEY_POS_W-1:0]  k_q, k_d;
  logic [BYTE_W-1:0]     sa_q, sa_d, sb_q, sb_d;
  logic [BYTE_W-1:0]     data_q, out_q, out_d;
  logic                  out_valid_q, out_valid_d;

  logic                  ram_we, ram_re;
  logic [BOX_ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [BYTE_W-1:0]     ram_wdata, ram_rdata;

  logic [BYTE_W-1:0]     key_bytes [KEY_BYTES];
  logic [KEY_LEN_W-1:0]  len_eff;
  logic                  k_last;
  logic [BYTE_W-1:0]     keystream;

  rc4_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BOX_DEPTH)
  ) u_box (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    for (int n = 0; n < KEY_BYTES / 2; n++) begin
      key_bytes[n]                 = key_low_i[n*BYTE_W +: BYTE_W];
      key_bytes[n + KEY_BYTES / 2] = key_high_i[n*BYTE_W +: BYTE_W];
    end
  end

  // saturate the key length into 1..MAX_KEY_BYTES
  always_comb begin
    if (key_length_i == '0) begin
      len_eff = LEN_ONE;
    end else if (key_length_i > LEN_MAX) begin
      len_eff = LEN_MAX;
    end else begin
      len_eff = key_length_i;
    end
  end

  assign k_last = ({1'b0, k_q} == (len_eff - LEN_ONE));

  // a box entry swapped this step is not yet in memory for the final read
  always_comb begin
    if (t_q == i_q) begin
      keystream = sb_q;
    end else if (t_q == j_q) begin
      keystream = sa_q;
    end else begin
      keystream = ram_rdata;
    end
  end

  always_comb begin
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    t_d         = t_q;
    sa_d        = sa_q;
    sb_d        = sb_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_we      = 1'b0;
    ram_waddr   = i_q;
    ram_wdata   = sa_q;
    ram_re      = 1'b0;
    ram_raddr   = i_q;
    unique case (cmd_i.op)
      DP_NOP: begin
      end
      DP_CLEAR: begin
        i_d = '0;
        j_d = '0;
        k_d = '0;
      end
      DP_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = i_q;
        ram_wdata = i_q;
        i_d       = i_q + 1'b1;
      end
      DP_KS_RD_A: begin
        ram_re    = 1'b1;
        ram_raddr = i_q;
      end
      DP_KS_RD_B: begin
        sa_d      = ram_rdata;
        j_d       = j_q + ram_rdata + key_bytes[k_q];
        k_d       = k_last ? '0 : k_q + 1'b1;
        ram_re    = 1'b1;
        ram_raddr = j_d;
      end
      DP_KS_WR_A: begin
        sb_d      = ram_rdata;
        ram_we    = 1'b1;
        ram_waddr = i_q;
        ram_wdata = ram_rdata;
      end
      DP_KS_WR_B: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = sa_q;
        i_d       = i_q + 1'b1;
      end
      DP_GEN_RD_I: begin
        i_d       = i_q + 1'b1;
        ram_re    = 1'b1;
        ram_raddr = i_d;
      end
      DP_GEN_RD_J: begin
        sa_d      = ram_rdata;
        j_d       = j_q + ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = j_d;
      end
      DP_GEN_SWAP: begin
        sb_d      = ram_rdata;
        ram_we    = 1'b1;
        ram_waddr = i_q;
        ram_wdata = ram_rdata;
        t_d       = sa_q + ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = t_d;
      end
      DP_GEN_OUT: begin
        ram_we      = 1'b1;
        ram_waddr   = j_q;
        ram_wdata   = sa_q;
        out_d       = data_q ^ keystream;
        out_valid_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q   <= t_d;
    sa_q  <= sa_d;
    sb_q  <= sb_d;
    out_q <= out_d;
    if (cmd_i.capture) begin
      data_q <= data_byte_i;
    end
  end

  assign status_o.i_last   = (i_q == '1);
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_byte_o        = out_q;
  assign out_valid_o       = out_valid_q;

endmodule

/* hdl/rc4_stream_cipher.sv */
// Top level of the RC4 byte stream cipher: key registers, sequencer and datapath.
//
// Usage: bytes enter on in_i (data_byte, first_of_message) and leave on out_o
// (out_byte), both valid/ready; a transfer happens when valid and ready are high
// at a rising edge. Each input byte gives exactly one output byte.
// The key lives in three registers on the APB port at byte addresses 0
// (key_low), 8 (key_high) and 16 (key_length); write them while idle.
// A byte flagged first_of_message, or the first byte after reset, starts with
// the key schedule (clear, 256 identity writes, 256 swap steps of two box
// reads and two swap writes each, index clear) before its keystream step.
// A keystream step runs through GEN_RD_I, GEN_RD_J, GEN_SWAP and GEN_OUT:
// three dependent box reads and the swap writes share the single-read,
// single-write box memory. GEN_OUT loads the output register, and a new
// byte is taken only once the sequencer is back in idle.
// A finished byte waits in the output register while the next byte is taken;
// when the receiver stalls, the step holds in its last cycle until the
// output register is free.
// Reset clears the indices, the keyed flag and the key registers (length 16);
// the box contents stay undefined until the next schedule writes them.
`include "rc4_stream_cipher_assert.svh"

module rc4_stream_cipher (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  rc4_in_if.sink                             in_i,
  rc4_out_if.source                          out_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rc4_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [rc4_pkg::REG_W-1:0]          pwdata,
  output logic [rc4_pkg::REG_W-1:0]          prdata,
  output logic                               pready
);
  import rc4_pkg::*;

  logic [REG_W-1:0]     key_low_q, key_high_q;
  logic [KEY_LEN_W-1:0] key_length_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 reg_write;

  dp_cmd_t              cmd;
  dp_status_t           status;
  logic                 in_ready;
  logic                 out_valid;
  logic [BYTE_W-1:0]    out_byte;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[REG_IDX_LSB +: REG_IDX_W];
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q    <= '0;
      key_high_q   <= '0;
      key_length_q <= KEY_LENGTH_RESET;
    end else if (reg_write) begin
      unique case (reg_idx)
        REG_KEY_LOW:    key_low_q    <= pwdata;
        REG_KEY_HIGH:   key_high_q   <= pwdata;
        REG_KEY_LENGTH: key_length_q <= pwdata[KEY_LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_KEY_LOW:    prdata = key_low_q;
      REG_KEY_HIGH:   prdata = key_high_q;
      REG_KEY_LENGTH: prdata = {{(REG_W - KEY_LEN_W){1'b0}}, key_length_q};
      default:        prdata = '0;
    endcase
  end

  rc4_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .first_i    (in_i.first_of_message),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rc4_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .data_byte_i  (in_i.data_byte),
    .key_low_i    (key_low_q),
    .key_high_i   (key_high_q),
    .key_length_i (key_length_q),
    .out_byte_o   (out_byte),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_o.ready)
  );

  assign in_i.ready     = in_ready;
  assign out_o.valid    = out_valid;
  assign out_o.out_byte = out_byte;

  // the sequencer is busy the cycle after every input transfer
  `RC4_ASSERT_NEXT(a_busy_after_transfer, clk_i, rst_ni, in_i.valid && in_i.ready, !in_i.ready)
  // a result never overwrites one that is still waiting
  `RC4_ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, cmd.op == DP_GEN_OUT, !out_o.valid || out_o.ready)
  // a result appears only after the final keystream step
  `RC4_ASSERT_IMPL(a_result_source, clk_i, rst_ni, $rose(out_o.valid), $past(cmd.op == DP_GEN_OUT))

endmodule

/* tb/tb_rc4_stream_cipher.sv */
// Self-checking testbench for the RC4 byte stream cipher: streams, key registers, stalls.
`timescale 1ns / 100ps

module tb_rc4_stream_cipher;
  import rc4_pkg::*;

  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RAND_PHASES  = 8;
  localparam int unsigned PHASE_ITEMS  = 245;

  typedef struct {
    logic [BYTE_W-1:0] data_byte;
    logic              first_of_message;
  } cipher_item_t;

  logic clk_i;
  logic rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [REG_W-1:0]      pwdata;
  logic [REG_W-1:0]      prdata;
  logic                  pready;

  rc4_in_if  in_bus ();
  rc4_out_if out_bus ();

  rc4_stream_cipher DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state: key registers as written, box and indices as the block holds them
  logic [63:0]        key_lo;
  logic [63:0]        key_hi;
  logic [KEY_LEN_W-1:0] key_len;
  logic [BYTE_W-1:0]  sbox [BOX_DEPTH];
  logic [BYTE_W-1:0]  idx_i;
  logic [BYTE_W-1:0]  idx_j;
  logic               keyed;

  cipher_item_t      pending_bytes [$];
  logic [BYTE_W-1:0] expected_bytes [$];
  cipher_item_t      next_item;
  logic [BYTE_W-1:0] want_byte;
  bit                no_idle;
  int unsigned       error_count;
  int unsigned       cycle_count;

  function automatic void run_key_schedule();
    int unsigned       n;
    int unsigned       p;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] kb;
    logic [BYTE_W-1:0] tmp;
    n = key_len;
    if (n < 1) n = 1;
    if (n > MAX_KEY_BYTES) n = MAX_KEY_BYTES;
    for (int a = 0; a < BOX_DEPTH; a++) sbox[a] = BYTE_W'(a);
    b = '0;
    for (int a = 0; a < BOX_DEPTH; a++) begin
      p  = a % n;
      kb = (p < 8) ? key_lo[8*p +: 8] : key_hi[8*(p-8) +: 8];
      b  = b + sbox[a] + kb;
      tmp     = sbox[a];
      sbox[a] = sbox[b];
      sbox[b] = tmp;
    end
    idx_i = '0;
    idx_j = '0;
    keyed = 1'b1;
  endfunction

  function automatic logic [BYTE_W-1:0] cipher_next_byte(logic [BYTE_W-1:0] data, logic first);
    logic [BYTE_W-1:0] tmp;
    logic [BYTE_W-1:0] t;
    if (first || !keyed) run_key_schedule();
    idx_i = idx_i + 1'b1;
    idx_j = idx_j + sbox[idx_i];
    tmp         = sbox[idx_i];
    sbox[idx_i] = sbox[idx_j];
    sbox[idx_j] = tmp;
    t = sbox[idx_i] + sbox[idx_j];
    return data ^ sbox[t];
  endfunction

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(99) < 13);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Input driver: predict on each transfer, then offer the next pending byte
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready)
        expected_bytes.push_back(cipher_next_byte(in_bus.data_byte, in_bus.first_of_message));
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_bytes.size() != 0 && !idle_now()) begin
          next_item = pending_bytes.pop_front();
          in_bus.valid            <= 1'b1;
          in_bus.data_byte        <= next_item.data_byte;
          in_bus.first_of_message <= next_item.first_of_message;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor with random back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected out_byte, expected none, actual %02h",
                   $time, out_bus.out_byte);
          error_count++;
        end else begin
          want_byte = expected_bytes.pop_front();
          if (out_bus.out_byte !== want_byte) begin
            $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                     $time, want_byte, out_bus.out_byte);
            error_count++;
          end
        end
      end
      out_bus.ready <= !idle_now();
    end
  end

  task automatic push_item(logic [BYTE_W-1:0] data, logic first);
    cipher_item_t item;
    item.data_byte        = data;
    item.first_of_message = first;
    pending_bytes.push_back(item);
  endtask

  task automatic write_key_reg(logic [REG_IDX_W-1:0] idx, logic [63:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(idx) << REG_IDX_LSB;
    pwdata  <= REG_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_KEY_LOW:    key_lo  = value;
      REG_KEY_HIGH:   key_hi  = value;
      REG_KEY_LENGTH: key_len = value[KEY_LEN_W-1:0];
      default: ;
    endcase
  endtask

  // Hold until every byte has gone through and the block is quiet
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_bus.valid || expected_bytes.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned msg_len;
    int unsigned len_pick;
    logic [63:0] len_val;

    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_bus.valid            = 1'b0;
    in_bus.data_byte        = '0;
    in_bus.first_of_message = 1'b0;
    out_bus.ready = 1'b0;
    no_idle     = 1'b0;
    error_count = 0;
    cycle_count = 0;
    key_lo  = '0;
    key_hi  = '0;
    key_len = KEY_LENGTH_RESET;
    idx_i   = '0;
    idx_j   = '0;
    keyed   = 1'b0;
    for (int a = 0; a < BOX_DEPTH; a++) sbox[a] = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset key; the very first byte keys the box without the message flag
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'h55, 1'b0);
    push_item(8'hAA, 1'b0);
    push_item(8'h0F, 1'b0);
    push_item(8'h00, 1'b1);
    push_item(8'hFF, 1'b0);
    push_item(8'h01, 1'b0);
    push_item(8'h80, 1'b0);
    wait_drained();

    // All-ones key, single byte in use
    write_key_reg(REG_KEY_LOW, '1);
    write_key_reg(REG_KEY_HIGH, '1);
    write_key_reg(REG_KEY_LENGTH, 64'd1);
    push_item(8'hFF, 1'b1);
    push_item(8'h00, 1'b0);
    push_item(8'h3C, 1'b0);
    wait_drained();

    // Length zero saturates to one
    write_key_reg(REG_KEY_LOW, {$urandom, $urandom});
    write_key_reg(REG_KEY_LENGTH, 64'd0);
    push_item(8'hA5, 1'b1);
    push_item(8'h5A, 1'b0);
    wait_drained();

    // Largest length saturates to the key size
    write_key_reg(REG_KEY_HIGH, {$urandom, $urandom});
    write_key_reg(REG_KEY_LENGTH, 64'd31);
    push_item(8'h00, 1'b1);
    push_item(8'hFF, 1'b0);
    wait_drained();

    // New key mid-message: old stream carries on until the next message start
    write_key_reg(REG_KEY_LOW, {$urandom, $urandom});
    write_key_reg(REG_KEY_LENGTH, 64'd17);
    write_key_reg(REG_UNUSED, '1);
    push_item(8'h12, 1'b0);
    push_item(8'h34, 1'b0);
    push_item(8'h56, 1'b1);
    wait_drained();

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      if (phase == 0) begin
        write_key_reg(REG_KEY_LOW, '0);
        write_key_reg(REG_KEY_HIGH, '0);
      end else if (phase == 1) begin
        write_key_reg(REG_KEY_LOW, '1);
        write_key_reg(REG_KEY_HIGH, '1);
      end else begin
        write_key_reg(REG_KEY_LOW, {$urandom, $urandom});
        write_key_reg(REG_KEY_HIGH, {$urandom, $urandom});
      end
      len_pick = $urandom_range(9);
      if (phase < 2)          len_val = 64'd16;
      else if (len_pick == 0) len_val = 64'd1;
      else if (len_pick == 1) len_val = 64'd16;
      else if (len_pick == 2) len_val = 64'($urandom_range(31, 17));
      else                    len_val = 64'($urandom_range(16, 1));
      write_key_reg(REG_KEY_LENGTH, len_val);
      if ($urandom_range(9) == 0) write_key_reg(REG_UNUSED, {$urandom, $urandom});

      no_idle = (phase == 3);
      for (int n = 0; n < PHASE_ITEMS; ) begin
        if ($urandom_range(9) != 0) begin
          // Well-formed message; now and then carry on the previous stream instead
          msg_len = $urandom_range(40, 1);
          for (int k = 0; k < msg_len && n < PHASE_ITEMS; k++, n++)
            push_item(BYTE_W'($urandom_range(255)),
                      (k == 0) && ($urandom_range(7) != 0));
        end else begin
          push_item(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
          n++;
        end
      end
      wait_drained();
      no_idle = 1'b0;
    end

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
